@@ hw/rtl/sle_pkg.sv @@
// shared types and constants for the serial line editor
`default_nettype none

package sle_pkg;

   localparam int BYTE_W    = 8;
   localparam int LIMIT_W   = 6;
   localparam int LEN_OUT_W = 5;
   localparam int KIND_W    = 2;

   localparam logic [BYTE_W-1:0] CH_CR          = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF          = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_BS          = 8'h08;
   localparam logic [BYTE_W-1:0] CH_DEL         = 8'h7F;
   localparam logic [BYTE_W-1:0] CH_SPACE       = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TELNET      = 8'hFF;
   localparam logic [BYTE_W-1:0] CH_FIRST_PRINT = 8'd32;

   localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EXIT = 2'd3;

   localparam logic [BYTE_W-1:0]  EXIT_A_RESET     = 8'd0;
   localparam logic [BYTE_W-1:0]  EXIT_B_RESET     = 8'd1;
   localparam logic [BYTE_W-1:0]  EXIT_C_RESET     = 8'd16;
   localparam logic [LIMIT_W-1:0] LINE_LIMIT_RESET = 6'd32;
   localparam logic [LIMIT_W-1:0] LIMIT_FLOOR      = 6'd2;
   localparam logic [1:0]         SKIP_TELNET      = 2'd2;

   typedef enum logic [1:0] {
      CSR_EXIT_A     = 2'd0,
      CSR_EXIT_B     = 2'd1,
      CSR_EXIT_C     = 2'd2,
      CSR_LINE_LIMIT = 2'd3
   } csr_idx_type;

   // what a received byte asks for
   typedef enum logic [2:0] {
      CLS_NONE  = 3'd0,
      CLS_EXIT  = 3'd1,
      CLS_ERASE = 3'd2,
      CLS_CR    = 3'd3,
      CLS_STORE = 3'd4,
      CLS_FULL  = 3'd5
   } cls_type;

   // source of the next result
   typedef enum logic [2:0] {
      SEL_EXIT = 3'd0,
      SEL_BS   = 3'd1,
      SEL_SP   = 3'd2,
      SEL_CR   = 3'd3,
      SEL_LF   = 3'd4,
      SEL_ECHO = 3'd5,
      SEL_LINE = 3'd6,
      SEL_END  = 3'd7
   } sel_type;

   typedef struct packed {
      logic    accept;
      logic    out_load;
      sel_type out_sel;
      logic    out_final;
      logic    rd_first;
      logic    rd_next;
   } cmd_type;

   typedef struct packed {
      cls_type cls;
      logic    out_free;
      logic    len_zero;
      logic    line_last;
   } status_type;

endpackage

`default_nettype wire

@@ hw/rtl/sle_req_if.sv @@
// received byte channel
`default_nettype none

interface sle_req_if;
   import sle_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sle_rsp_if.sv @@
// result channel
`default_nettype none

interface sle_rsp_if;
   import sle_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    result_kind;
   logic [BYTE_W-1:0]    result_byte;
   logic [LEN_OUT_W-1:0] line_length;
   logic                 final_of_run;

   modport source (output valid, output result_kind, output result_byte,
                   output line_length, output final_of_run, input ready);
   modport sink   (input valid, input result_kind, input result_byte,
                   input line_length, input final_of_run, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/serial_line_editor.sv @@
// serial line editor top level
//
//   port     dir  transfer on         carries
//   req_if   in   valid && ready      rx_byte
//   rsp_if   out  valid && ready      result_kind, result_byte, line_length, final_of_run
//   csr_*    in   csr_we              csr_index, csr_wdata
//
// a byte is taken, then its results leave at one per cycle while rsp_if
// does not stall, through the result register: up to 34 results (CR on a
// full line); line bytes come from the line store, read one entry ahead
// bytes that yield no result free the input again in the next cycle
// req_if.ready is high while the sequencer is idle, even if the last result
// waits in the result register; a stall on rsp_if holds the sequencer
// synchronous reset clears the counters, settings and result valid; no clearing pass
`default_nettype none

module serial_line_editor
   import sle_pkg::*;
#(
   parameter int LINE_LEN = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   sle_req_if.sink                req_if,
   sle_rsp_if.source              rsp_if,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [BYTE_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       in_ready;

   sle_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_ready (in_ready),
      .status   (status),
      .cmd      (cmd)
   );

   sle_dp #(
      .LINE_LEN (LINE_LEN)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rx_byte   (req_if.rx_byte),
      .cmd       (cmd),
      .status    (status),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_kind  (rsp_if.result_kind),
      .out_byte  (rsp_if.result_byte),
      .out_len   (rsp_if.line_length),
      .out_final (rsp_if.final_of_run)
   );

   assign req_if.ready = in_ready;

   // a line end always closes the run of its byte
   a_end_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.result_kind == KIND_END |-> rsp_if.final_of_run)
      else $error("line end without final flag");

   // length is reported only on a line end
   a_len_only_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.result_kind != KIND_END |-> rsp_if.line_length == '0)
      else $error("line length outside line end");

   // a byte with results blocks the input while they are sent
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && status.cls != CLS_NONE |=> !req_if.ready)
      else $error("input taken while results pending");

   // a result is only loaded while the input is closed
   a_no_load_in_idle: assert property (@(posedge clock) disable iff (reset)
      in_ready |-> !cmd.out_load)
      else $error("result loaded while idle");

endmodule

`default_nettype wire

@@ hw/rtl/sle_ctrl.sv @@
// result sequencer state machine
`default_nettype none

module sle_ctrl
   import sle_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_EXIT  = 11'b000_0000_0010,
      ST_BS1   = 11'b000_0000_0100,
      ST_SP    = 11'b000_0000_1000,
      ST_BS2   = 11'b000_0001_0000,
      ST_CR    = 11'b000_0010_0000,
      ST_LF    = 11'b000_0100_0000,
      ST_ECHO  = 11'b000_1000_0000,
      ST_ECHOF = 11'b001_0000_0000,
      ST_LINE  = 11'b010_0000_0000,
      ST_END   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      in_ready      = 1'b0;
      cmd.accept    = 1'b0;
      cmd.out_load  = 1'b0;
      cmd.out_sel   = SEL_ECHO;
      cmd.out_final = 1'b0;
      cmd.rd_first  = 1'b0;
      cmd.rd_next   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.accept = 1'b1;
               unique case (status.cls)
                  CLS_EXIT:  state_in = ST_EXIT;
                  CLS_ERASE: state_in = ST_BS1;
                  CLS_CR:    state_in = ST_CR;
                  CLS_STORE: state_in = ST_ECHO;
                  CLS_FULL:  state_in = ST_ECHOF;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_EXIT: begin
            cmd.out_sel   = SEL_EXIT;
            cmd.out_final = 1'b1;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_BS1: begin
            cmd.out_sel = SEL_BS;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_SP;
            end
         end
         ST_SP: begin
            cmd.out_sel = SEL_SP;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_BS2;
            end
         end
         ST_BS2: begin
            cmd.out_sel   = SEL_BS;
            cmd.out_final = 1'b1;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CR: begin
            cmd.out_sel = SEL_CR;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_LF;
            end
         end
         ST_LF: begin
            cmd.out_sel = SEL_LF;
            if (status.out_free) begin
               // fetch the first stored byte alongside the last echo
               cmd.out_load = 1'b1;
               cmd.rd_first = 1'b1;
               state_in     = status.len_zero ? ST_END : ST_LINE;
            end
         end
         ST_ECHO: begin
            cmd.out_sel   = SEL_ECHO;
            cmd.out_final = 1'b1;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_ECHOF: begin
            cmd.out_sel = SEL_ECHO;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.rd_first = 1'b1;
               state_in     = status.len_zero ? ST_END : ST_LINE;
            end
         end
         ST_LINE: begin
            cmd.out_sel = SEL_LINE;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.rd_next  = 1'b1;
               state_in     = status.line_last ? ST_END : ST_LINE;
            end
         end
         ST_END: begin
            cmd.out_sel   = SEL_END;
            cmd.out_final = 1'b1;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/sle_dp.sv @@
// line editor datapath: registers, line store, counters and result register
`default_nettype none

module sle_dp
   import sle_pkg::*;
#(
   parameter int LINE_LEN = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_index,
   input  wire logic [BYTE_W-1:0]    csr_wdata,
   input  wire logic [BYTE_W-1:0]    rx_byte,
   input  wire cmd_type              cmd,
   output status_type                status,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [KIND_W-1:0]         out_kind,
   output logic [BYTE_W-1:0]         out_byte,
   output logic [LEN_OUT_W-1:0]      out_len,
   output logic                      out_final
);

   localparam int IDX_W = (LINE_LEN > 2) ? $clog2(LINE_LEN) : 1;
   localparam logic [LIMIT_W-1:0] LIM_MAX = LIMIT_W'(LINE_LEN);

   logic [BYTE_W-1:0]  exit_a_ff, exit_b_ff, exit_c_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [IDX_W-1:0]   fill_ff, fill_in;
   logic [1:0]         skip_ff, skip_in;
   logic [IDX_W-1:0]   len_ff, len_in;
   logic [IDX_W-1:0]   k_ff;
   logic [BYTE_W-1:0]  byte_ff;
   logic [BYTE_W-1:0]  rd_data_ff;
   logic [BYTE_W-1:0]  line_mem [LINE_LEN];

   logic               rsp_valid_ff;
   logic [KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic [LEN_OUT_W-1:0] rsp_len_ff, rsp_len_in;
   logic               rsp_final_ff;

   logic [LIMIT_W-1:0] lim, held, fill_w, len_w;
   logic               is_telnet;
   logic               mem_we, mem_re;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W:0]     k_plus;
   cls_type            cls;

   // held bytes allowed with the limit clamped to the buffer
   always_comb begin
      lim = limit_ff;
      if (lim < LIMIT_FLOOR) begin
         lim = LIMIT_FLOOR;
      end else if (lim > LIM_MAX) begin
         lim = LIM_MAX;
      end
      held   = lim - LIMIT_W'(1);
      fill_w = LIMIT_W'(fill_ff);
      len_w  = (fill_w > held) ? held : fill_w;
   end

   always_comb begin
      is_telnet = 1'b0;
      priority if (skip_ff != 2'd0) begin
         cls = CLS_NONE;
      end else if (rx_byte == exit_a_ff || rx_byte == exit_b_ff || rx_byte == exit_c_ff) begin
         cls = CLS_EXIT;
      end else if ((rx_byte == CH_BS || rx_byte == CH_DEL) && fill_ff != '0) begin
         cls = CLS_ERASE;
      end else if (rx_byte == CH_CR) begin
         cls = CLS_CR;
      end else if (rx_byte < CH_FIRST_PRINT || rx_byte == CH_DEL) begin
         cls = CLS_NONE;
      end else if (rx_byte == CH_TELNET) begin
         cls       = CLS_NONE;
         is_telnet = 1'b1;
      end else if (fill_w < held) begin
         cls = CLS_STORE;
      end else begin
         cls = CLS_FULL;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      skip_in = skip_ff;
      len_in  = len_ff;
      mem_we  = 1'b0;
      if (cmd.accept) begin
         if (skip_ff != 2'd0) begin
            skip_in = skip_ff - 2'd1;
         end else if (is_telnet) begin
            skip_in = SKIP_TELNET;
         end
         unique case (cls)
            CLS_EXIT:  fill_in = '0;
            CLS_ERASE: fill_in = fill_ff - IDX_W'(1);
            CLS_STORE: begin
               fill_in = fill_ff + IDX_W'(1);
               mem_we  = 1'b1;
            end
            CLS_CR, CLS_FULL: begin
               len_in  = IDX_W'(len_w);
               fill_in = '0;
            end
            default: begin
               fill_in = fill_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exit_a_ff <= EXIT_A_RESET;
         exit_b_ff <= EXIT_B_RESET;
         exit_c_ff <= EXIT_C_RESET;
         limit_ff  <= LINE_LIMIT_RESET;
         fill_ff   <= '0;
         skip_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         skip_ff <= skip_in;
         if (csr_we) begin
            unique case (csr_idx_type'(csr_index))
               CSR_EXIT_A:     exit_a_ff <= csr_wdata;
               CSR_EXIT_B:     exit_b_ff <= csr_wdata;
               CSR_EXIT_C:     exit_c_ff <= csr_wdata;
               CSR_LINE_LIMIT: limit_ff  <= csr_wdata[LIMIT_W-1:0];
               default:        limit_ff  <= limit_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      if (cmd.accept) begin
         byte_ff <= rx_byte;
      end
   end

   // line read pointer, one byte ahead of the result register
   assign k_plus  = {1'b0, k_ff} + (IDX_W+1)'(1);
   assign rd_addr = cmd.rd_first ? '0 : k_plus[IDX_W-1:0];
   assign mem_re  = cmd.rd_first | cmd.rd_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (cmd.rd_first) begin
         k_ff <= '0;
      end else if (cmd.rd_next) begin
         k_ff <= k_plus[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[fill_ff] <= rx_byte;
      end
      if (mem_re) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   always_comb begin
      rsp_len_in = '0;
      unique case (cmd.out_sel)
         SEL_EXIT: begin
            rsp_kind_in = KIND_EXIT;
            rsp_byte_in = byte_ff;
         end
         SEL_BS: begin
            rsp_kind_in = KIND_ECHO;
            rsp_byte_in = CH_BS;
         end
         SEL_SP: begin
            rsp_kind_in = KIND_ECHO;
            rsp_byte_in = CH_SPACE;
         end
         SEL_CR: begin
            rsp_kind_in = KIND_ECHO;
            rsp_byte_in = CH_CR;
         end
         SEL_LF: begin
            rsp_kind_in = KIND_ECHO;
            rsp_byte_in = CH_LF;
         end
         SEL_ECHO: begin
            rsp_kind_in = KIND_ECHO;
            rsp_byte_in = byte_ff;
         end
         SEL_LINE: begin
            rsp_kind_in = KIND_LINE;
            rsp_byte_in = rd_data_ff;
         end
         SEL_END: begin
            rsp_kind_in = KIND_END;
            rsp_byte_in = '0;
            rsp_len_in  = LEN_OUT_W'(len_ff);
         end
         default: begin
            rsp_kind_in = KIND_ECHO;
            rsp_byte_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_byte_ff  <= rsp_byte_in;
         rsp_len_ff   <= rsp_len_in;
         rsp_final_ff <= cmd.out_final;
      end
   end

   assign status.cls       = cls;
   assign status.out_free  = ~rsp_valid_ff | out_ready;
   assign status.len_zero  = (len_ff == '0);
   assign status.line_last = (k_plus == {1'b0, len_ff});

   assign out_valid = rsp_valid_ff;
   assign out_kind  = rsp_kind_ff;
   assign out_byte  = rsp_byte_ff;
   assign out_len   = rsp_len_ff;
   assign out_final = rsp_final_ff;

endmodule

`default_nettype wire

@@ test/tb_serial_line_editor.sv @@
// testbench for the serial line editor: line tracking scoreboard, byte stimulus and result checks
`timescale 1ns / 1ps

module tb_serial_line_editor;
   import sle_pkg::*;

   localparam int LINE_CAP = 32;
   localparam int PHASE_ITEMS = 50;

   typedef logic [BYTE_W-1:0] byte_q_type[$];

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [BYTE_W-1:0]    data;
      logic [LEN_OUT_W-1:0] len;
      logic                 last;
   } edit_result_type;

   class edit_scoreboard;
      logic [BYTE_W-1:0]  exit_a;
      logic [BYTE_W-1:0]  exit_b;
      logic [BYTE_W-1:0]  exit_c;
      logic [LIMIT_W-1:0] limit_reg;
      logic [BYTE_W-1:0]  line_buf[LINE_CAP];
      int                 fill;
      int                 skip;
      edit_result_type    expected_q[$];
      int                 errors;
      int                 bytes_seen;
      int                 results_seen;
      int                 lines;
      int                 full_lines;
      int                 erases;
      int                 exits;
      int                 skips;

      function new();
         exit_a = EXIT_A_RESET;
         exit_b = EXIT_B_RESET;
         exit_c = EXIT_C_RESET;
         limit_reg = LINE_LIMIT_RESET;
         fill = 0;
         skip = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [BYTE_W-1:0] val);
         case (idx)
            CSR_EXIT_A:     exit_a = val;
            CSR_EXIT_B:     exit_b = val;
            CSR_EXIT_C:     exit_c = val;
            CSR_LINE_LIMIT: limit_reg = val[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      // usable bytes per line, with the limit clamped to the buffer
      function int held_max();
         int lim;
         lim = limit_reg;
         if (lim < LIMIT_FLOOR) lim = LIMIT_FLOOR;
         if (lim > LINE_CAP) lim = LINE_CAP;
         return lim - 1;
      endfunction

      function void add(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                        logic [LEN_OUT_W-1:0] len);
         edit_result_type r;
         r.kind = kind;
         r.data = data;
         r.len = len;
         r.last = 1'b0;
         expected_q.push_back(r);
      endfunction

      function void flush_line();
         int len;
         len = fill;
         if (len > held_max()) len = held_max();
         for (int k = 0; k < len; k++) add(KIND_LINE, line_buf[k], '0);
         add(KIND_END, '0, len[LEN_OUT_W-1:0]);
         fill = 0;
         lines++;
      endfunction

      // predicts what one accepted byte produces; returns the result count
      function int take_byte(logic [BYTE_W-1:0] b);
         int start;
         edit_result_type r;
         start = expected_q.size();
         bytes_seen++;
         if (skip != 0) begin
            skip--;
            return 0;
         end
         if (b == exit_a || b == exit_b || b == exit_c) begin
            fill = 0;
            exits++;
            add(KIND_EXIT, b, '0);
         end else if ((b == CH_BS || b == CH_DEL) && fill != 0) begin
            fill--;
            erases++;
            add(KIND_ECHO, CH_BS, '0);
            add(KIND_ECHO, CH_SPACE, '0);
            add(KIND_ECHO, CH_BS, '0);
         end else if (b == CH_CR) begin
            add(KIND_ECHO, CH_CR, '0);
            add(KIND_ECHO, CH_LF, '0);
            flush_line();
         end else if (b < CH_FIRST_PRINT || b == CH_DEL) begin
            return 0;
         end else if (b == CH_TELNET) begin
            skip = SKIP_TELNET;
            skips++;
            return 0;
         end else begin
            add(KIND_ECHO, b, '0);
            if (fill < held_max()) begin
               line_buf[fill % LINE_CAP] = b;
               fill++;
            end else begin
               full_lines++;
               flush_line();
            end
         end
         r = expected_q.pop_back();
         r.last = 1'b1;
         expected_q.push_back(r);
         return expected_q.size() - start;
      endfunction

      task report(string what);
         $display("%0t mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_output(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                        logic [LEN_OUT_W-1:0] len, logic last);
         edit_result_type want;
         results_seen++;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result kind %0d byte %02h", kind, data));
            return;
         end
         want = expected_q.pop_front();
         if (kind !== want.kind)
            report($sformatf("result_kind %0d, wanted %0d", kind, want.kind));
         if (data !== want.data)
            report($sformatf("result_byte %02h, wanted %02h", data, want.data));
         if (len !== want.len)
            report($sformatf("line_length %0d, wanted %0d", len, want.len));
         if (last !== want.last)
            report($sformatf("final_of_run %b, wanted %b", last, want.last));
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [BYTE_W-1:0] csr_wdata;

   sle_req_if req_if();
   sle_rsp_if rsp_if();

   edit_scoreboard sb;
   bit send_quiet;
   bit rsp_quiet;
   bit long_hold;
   int counted;

   serial_line_editor #(.LINE_LEN(LINE_CAP)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("tb_serial_line_editor: errors");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(15, 50);
      return $urandom_range(1, 3);
   endfunction

   // receiver: random stalls, plus one long hold-off when asked
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_if.ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end else if (rsp_quiet || $urandom_range(0, 3) != 0) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_output(rsp_if.result_kind, rsp_if.result_byte,
                         rsp_if.line_length, rsp_if.final_of_run);
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      void'(sb.take_byte(b));
      counted++;
      if (!send_quiet && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   task automatic send_seq(input byte_q_type s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   // drain all pending results, then give a no-result byte time to clear
   task automatic settle();
      req_if.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [BYTE_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic write_config(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b,
                               input logic [BYTE_W-1:0] c, input logic [BYTE_W-1:0] lim);
      settle();
      write_reg(CSR_EXIT_A, a);
      write_reg(CSR_EXIT_B, b);
      write_reg(CSR_EXIT_C, c);
      write_reg(CSR_LINE_LIMIT, lim);
      csr_we <= 1'b0;
   endtask

   // one typed line: mostly printable, with erasures, telnet options, noise and exit codes
   task automatic random_line();
      int len;
      int r;
      logic [BYTE_W-1:0] b;
      len = $urandom_range(0, sb.held_max() + 2);
      for (int k = 0; k < len; k++) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            b = BYTE_W'($urandom_range(CH_FIRST_PRINT, CH_TELNET - 1));
            if (b == CH_DEL) b = CH_DEL - 1;
            send_byte(b);
         end else if (r < 88) begin
            send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
         end else if (r < 92) begin
            send_byte(CH_TELNET);
            send_byte(BYTE_W'($urandom_range(0, 255)));
            send_byte(BYTE_W'($urandom_range(0, 255)));
         end else if (r < 95) begin
            send_byte(BYTE_W'($urandom_range(0, CH_FIRST_PRINT - 1)));
         end else begin
            case ($urandom_range(0, 2))
               0: send_byte(sb.exit_a);
               1: send_byte(sb.exit_b);
               default: send_byte(sb.exit_c);
            endcase
         end
      end
      r = $urandom_range(0, 99);
      if (r < 70) send_byte(CH_CR);
      else if (r >= 85) send_byte(BYTE_W'($urandom_range(0, 255)));
   endtask

   task automatic random_phase();
      int goal;
      goal = counted + PHASE_ITEMS;
      while (counted < goal) random_line();
   endtask

   initial begin
      sb = new();
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_EXIT_A;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.rx_byte <= '0;
      send_quiet = 1'b0;
      rsp_quiet = 1'b0;
      long_hold = 1'b0;
      counted = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: store, erase, finish, drops, exits, telnet swallow
      send_seq('{8'h61, 8'h7E, CH_SPACE, 8'h80, CH_BS, CH_DEL, CH_CR,
                 CH_BS, CH_DEL, 8'h1F, CH_LF, EXIT_A_RESET, 8'h71, EXIT_B_RESET,
                 EXIT_C_RESET, CH_TELNET, EXIT_A_RESET, EXIT_C_RESET,
                 CH_TELNET, CH_TELNET, CH_CR});
      // exit codes that shadow edit bytes, shortest line
      write_config(CH_TELNET, CH_CR, CH_DEL, LIMIT_FLOOR);
      send_seq('{CH_TELNET, 8'h61, 8'h62, CH_CR});
      // limit lowered under a partly typed line
      write_config(EXIT_A_RESET, EXIT_B_RESET, EXIT_C_RESET, LINE_LIMIT_RESET);
      send_seq('{8'h68, 8'h65, 8'h6C});
      write_config(EXIT_A_RESET, EXIT_B_RESET, EXIT_C_RESET, 8'd3);
      send_seq('{8'h6C, CH_CR});

      send_quiet = 1'b1;
      rsp_quiet = 1'b1;
      write_config(EXIT_A_RESET, EXIT_B_RESET, EXIT_C_RESET, LINE_LIMIT_RESET);
      random_phase();

      send_quiet = 1'b0;
      rsp_quiet = 1'b0;
      write_config(CH_TELNET, CH_CR, 8'h41, LIMIT_FLOOR);
      random_phase();

      write_config(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                   BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(2, LINE_CAP)));
      long_hold = 1'b1;
      random_phase();

      // limit field of zero after masking clamps up to the floor
      write_config(CH_BS, CH_DEL, 8'h7E, 8'h40);
      random_phase();

      rsp_quiet = 1'b1;
      write_config(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                   BYTE_W'($urandom_range(0, 255)), 8'hFF);
      random_phase();

      rsp_quiet = 1'b0;
      write_config(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                   BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
      random_phase();

      settle();
      repeat (40) @(posedge clock);

      $display("run covered %0d bytes and %0d results: %0d lines (%0d ended full),",
               sb.bytes_seen, sb.results_seen, sb.lines, sb.full_lines);
      $display("  %0d erasures, %0d exits, %0d telnet options, %0d mismatches",
               sb.erases, sb.exits, sb.skips, sb.errors);
      if (sb.errors == 0) begin
         $display("tb_serial_line_editor: clean");
      end else begin
         $display("tb_serial_line_editor: errors");
      end
      $finish;
   end

endmodule
